[hw/rtl/assert_macros.svh]
// Assertion helpers for segment_ack_window_tracker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define SAWT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define SAWT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sawt_pkg.sv]
package sawt_pkg;

    localparam int unsigned WindowBitsDef   = 2048;
    localparam int unsigned SegmentBytesDef = 4096;
    localparam int unsigned QueueDepthDef   = 16;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_SEND = 2'd1,
        OP_ACK  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_PUSH = 2'd0,
        KIND_SEG  = 2'd1,
        KIND_ACK  = 2'd2,
        KIND_DONE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_STALE   = 3'd1,
        ST_FUTURE  = 3'd2,
        ST_OUTSIDE = 3'd3,
        ST_FULL    = 3'd4,
        ST_NOTHING = 3'd5
    } status_t;

    // One queued work request
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] msg;
        logic [31:0] first_seq;
        logic [31:0] seg_count;
        logic [31:0] bytes_left;
    } entry_t;

    // One result item
    typedef struct packed {
        kind_t       kind;
        status_t     status;
        logic [31:0] work_id;
        logic [31:0] msg;
        logic [31:0] seq;
        logic [31:0] amount;
    } result_t;

endpackage

[hw/rtl/sawt_div.sv]
module sawt_div #(
    parameter int unsigned SEGMENT_BYTES = sawt_pkg::SegmentBytesDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    output logic        busy,
    output logic [31:0] quotient
);

    // Reciprocal of the segment size scaled by 2^32, rounded down
    localparam logic [63:0] Recip64 = (64'd1 << 32) / 64'(SEGMENT_BYTES);
    localparam logic [31:0] Recip   = Recip64[31:0];
    localparam logic [31:0] Dvs     = 32'(SEGMENT_BYTES);

    typedef enum logic [3:0] {
        P_IDLE = 4'd1,
        P_MUL  = 4'd2,
        P_SUB  = 4'd4,
        P_FIX  = 4'd8
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [31:0]     n_reg, n_next;
    logic [31:0]     q_reg, q_next;
    logic [31:0]     r_reg, r_next;
    logic [63:0]     prod;
    logic [31:0]     qd;

    assign prod = 64'(n_reg) * 64'(Recip);
    assign qd   = q_reg * Dvs;

    // Estimate the quotient by the reciprocal, then settle the remainder
    always_comb begin
        phase_next = phase_reg;
        n_next     = n_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        case (phase_reg)
            P_IDLE: begin
                if (start) begin
                    n_next     = dividend;
                    phase_next = P_MUL;
                end
            end
            P_MUL: begin
                q_next     = prod[63:32];
                phase_next = P_SUB;
            end
            P_SUB: begin
                r_next     = n_reg - qd;
                phase_next = P_FIX;
            end
            P_FIX: begin
                // the estimate may sit one below the true quotient
                if (r_reg >= Dvs) begin
                    q_next = q_reg + 32'd1;
                    r_next = r_reg - Dvs;
                end
                phase_next = P_IDLE;
            end
            default: begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= P_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
        n_reg <= n_next;
        q_reg <= q_next;
        r_reg <= r_next;
    end

    // Round up when a remainder is left
    assign busy     = (phase_reg != P_IDLE);
    assign quotient = q_reg + 32'(r_reg != '0);

endmodule

[hw/rtl/segment_ack_window_tracker.sv]
// One item at a time; s_ready is high only while idle. Push: full check, divide, then emit
// and queue write, plus output wait. Send: scan the queued requests, then issue a segment.
// Ack: check the sequence number; if accepted, set its bit, advance the pointer over set
// bitmap bits and, on an advance, check each queued request; the bitmap has one memory port.
// Reset is synchronous, active low; afterwards a clearing pass over all WINDOW_BITS entries
// sweeps the bitmap memory while s_ready stays low.
module segment_ack_window_tracker #(
    parameter int unsigned WINDOW_BITS   = sawt_pkg::WindowBitsDef,
    parameter int unsigned SEGMENT_BYTES = sawt_pkg::SegmentBytesDef,
    parameter int unsigned QUEUE_DEPTH   = sawt_pkg::QueueDepthDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [31:0] s_work_id,
    input  logic [31:0] s_work_bytes,
    input  logic [31:0] s_ack_seq,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [2:0]  m_status,
    output logic [31:0] m_out_work_id,
    output logic [31:0] m_msg_num,
    output logic [31:0] m_seq_num,
    output logic [31:0] m_amount,
    output logic        m_last
);
    import sawt_pkg::*;
    `include "assert_macros.svh"

    localparam int unsigned IDXW = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
    localparam int unsigned KW   = $clog2(WINDOW_BITS + 1);
    localparam int unsigned QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned FW   = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDXW-1:0] LastIdx = IDXW'(WINDOW_BITS - 1);
    localparam logic [IDXW:0]   WinI    = (IDXW + 1)'(WINDOW_BITS);
    localparam logic [KW-1:0]   WinK    = KW'(WINDOW_BITS);
    localparam logic [31:0]     Win32   = 32'(WINDOW_BITS);
    localparam logic [31:0]     Seg32   = 32'(SEGMENT_BYTES);
    localparam logic [FW-1:0]   DepthF  = FW'(QUEUE_DEPTH);

    typedef enum logic [13:0] {
        S_CLEAR    = 14'd1,
        S_IDLE     = 14'd2,
        S_PUSH     = 14'd4,
        S_DIV      = 14'd8,
        S_PUSHW    = 14'd16,
        S_SEND_RD  = 14'd32,
        S_SEND_CHK = 14'd64,
        S_ACK_CHK  = 14'd128,
        S_ACK_SET  = 14'd256,
        S_ADV_RD   = 14'd512,
        S_ADV_CHK  = 14'd1024,
        S_CMP_RD   = 14'd2048,
        S_CMP_CHK  = 14'd4096,
        S_DONE     = 14'd8192
    } state_t;

    state_t          state_reg, state_next;
    logic [31:0]     oldest_reg, oldest_next;
    logic [31:0]     nts_reg, nts_next;
    logic [31:0]     nsa_reg, nsa_next;
    logic [31:0]     nmsg_reg, nmsg_next;
    logic [IDXW-1:0] base_reg, base_next;
    logic [IDXW-1:0] scan_reg, scan_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [31:0]     off_reg, off_next;
    logic [31:0]     span_reg, span_next;
    logic [31:0]     id_reg, id_next;
    logic [31:0]     bytes_reg, bytes_next;
    logic [31:0]     ack_reg, ack_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [FW-1:0]   i_reg, i_next;
    logic [FW-1:0]   w_reg, w_next;
    logic            pend_valid_reg, pend_valid_next;
    result_t         pend_reg, pend_next;
    logic            m_valid_reg, m_valid_next;
    result_t         m_reg, m_next;
    logic            m_last_reg, m_last_next;

    // Bitmap memory, kept circular with base_reg at the oldest unacked segment
    logic            bm_mem [WINDOW_BITS];
    logic            bm_q_reg;
    logic            bm_we;
    logic [IDXW-1:0] bm_waddr;
    logic            bm_wdata;

    // Work request queue memory
    entry_t          q_mem [QUEUE_DEPTH];
    entry_t          q_q_reg;
    logic            q_we;
    logic [QW-1:0]   q_waddr;
    entry_t          q_wdata;

    logic            div_start;
    logic            div_busy;
    logic [31:0]     div_quot;

    logic            out_free;
    logic            can_emit;
    logic            emit_req;
    result_t         emit_res;

    logic [31:0]     seg;
    logic [31:0]     endv;
    logic [31:0]     rem;
    logic [31:0]     sp;
    logic            fin;
    logic [IDXW:0]   asum;
    logic [IDXW-1:0] scan_inc;
    logic            take_op;

    sawt_div #(
        .SEGMENT_BYTES(SEGMENT_BYTES)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (bytes_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign can_emit = !pend_valid_reg || out_free;

    // Datapath helpers
    assign seg      = (q_q_reg.bytes_left > Seg32) ? Seg32 : q_q_reg.bytes_left;
    assign endv     = q_q_reg.first_seq + q_q_reg.seg_count;
    assign rem      = endv - oldest_reg;
    assign sp       = nsa_reg - oldest_reg;
    assign fin      = (rem == 32'd0) || (rem > sp);
    assign asum     = {1'b0, base_reg} + off_reg[IDXW:0];
    assign scan_inc = (scan_reg == LastIdx) ? '0 : scan_reg + IDXW'(1);
    assign take_op  = s_valid && s_ready && (op_t'(s_op) != OP_NONE);

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        oldest_next = oldest_reg;
        nts_next    = nts_reg;
        nsa_next    = nsa_reg;
        nmsg_next   = nmsg_reg;
        base_next   = base_reg;
        scan_next   = scan_reg;
        k_next      = k_reg;
        off_next    = off_reg;
        span_next   = span_reg;
        id_next     = id_reg;
        bytes_next  = bytes_reg;
        ack_next    = ack_reg;
        fill_next   = fill_reg;
        i_next      = i_reg;
        w_next      = w_reg;
        bm_we       = 1'b0;
        bm_waddr    = scan_reg;
        bm_wdata    = 1'b0;
        q_we        = 1'b0;
        q_waddr     = w_reg[QW-1:0];
        q_wdata     = q_q_reg;
        div_start   = 1'b0;
        emit_req    = 1'b0;
        emit_res    = result_t'(0);
        s_ready     = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                bm_we = 1'b1;
                if (scan_reg == LastIdx) begin
                    scan_next  = '0;
                    state_next = S_IDLE;
                end else begin
                    scan_next = scan_inc;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    id_next    = s_work_id;
                    bytes_next = s_work_bytes;
                    ack_next   = s_ack_seq;
                    i_next     = '0;
                    case (op_t'(s_op))
                        OP_PUSH: state_next = S_PUSH;
                        OP_SEND: state_next = S_SEND_RD;
                        OP_ACK:  state_next = S_ACK_CHK;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_PUSH: begin
                if (fill_reg == DepthF) begin
                    emit_req        = 1'b1;
                    emit_res.kind   = KIND_PUSH;
                    emit_res.status = ST_FULL;
                    if (can_emit) begin
                        state_next = S_DONE;
                    end
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (!div_busy) begin
                    state_next = S_PUSHW;
                end
            end
            S_PUSHW: begin
                emit_req         = 1'b1;
                emit_res.kind    = KIND_PUSH;
                emit_res.status  = ST_OK;
                emit_res.work_id = id_reg;
                emit_res.msg     = nmsg_reg;
                emit_res.seq     = nsa_reg;
                emit_res.amount  = div_quot;
                if (can_emit) begin
                    q_we               = 1'b1;
                    q_waddr            = fill_reg[QW-1:0];
                    q_wdata.id         = id_reg;
                    q_wdata.msg        = nmsg_reg;
                    q_wdata.first_seq  = nsa_reg;
                    q_wdata.seg_count  = div_quot;
                    q_wdata.bytes_left = bytes_reg;
                    fill_next          = fill_reg + FW'(1);
                    nmsg_next          = nmsg_reg + 32'd1;
                    nsa_next           = nsa_reg + div_quot;
                    state_next         = S_DONE;
                end
            end
            S_SEND_RD: begin
                if (i_reg >= fill_reg) begin
                    emit_req        = 1'b1;
                    emit_res.kind   = KIND_SEG;
                    emit_res.status = ST_NOTHING;
                    if (can_emit) begin
                        state_next = S_DONE;
                    end
                end else begin
                    state_next = S_SEND_CHK;
                end
            end
            S_SEND_CHK: begin
                if (q_q_reg.bytes_left != 32'd0) begin
                    emit_req         = 1'b1;
                    emit_res.kind    = KIND_SEG;
                    emit_res.status  = ST_OK;
                    emit_res.work_id = q_q_reg.id;
                    emit_res.msg     = q_q_reg.msg;
                    emit_res.seq     = nts_reg;
                    emit_res.amount  = seg;
                    if (can_emit) begin
                        q_we               = 1'b1;
                        q_waddr            = i_reg[QW-1:0];
                        q_wdata.bytes_left = q_q_reg.bytes_left - seg;
                        nts_next           = nts_reg + 32'd1;
                        state_next         = S_DONE;
                    end
                end else begin
                    i_next     = i_reg + FW'(1);
                    state_next = S_SEND_RD;
                end
            end
            S_ACK_CHK: begin
                off_next     = ack_reg - oldest_reg;
                span_next    = nts_reg - oldest_reg;
                emit_req     = 1'b1;
                emit_res.kind = KIND_ACK;
                emit_res.seq = ack_reg;
                if (off_next[31]) begin
                    emit_res.status = ST_STALE;
                end else if (off_next >= span_next) begin
                    emit_res.status = ST_FUTURE;
                end else if (off_next >= Win32) begin
                    emit_res.status = ST_OUTSIDE;
                end else begin
                    emit_res.status = ST_OK;
                end
                if (can_emit) begin
                    state_next = (emit_res.status == ST_OK) ? S_ACK_SET : S_DONE;
                end
            end
            S_ACK_SET: begin
                bm_we      = 1'b1;
                bm_wdata   = 1'b1;
                bm_waddr   = (asum >= WinI) ? IDXW'(asum - WinI) : IDXW'(asum);
                scan_next  = base_reg;
                k_next     = '0;
                state_next = S_ADV_RD;
            end
            S_ADV_RD: begin
                state_next = S_ADV_CHK;
            end
            S_ADV_CHK: begin
                if (bm_q_reg && (32'(k_reg) < span_reg) && (k_reg < WinK)) begin
                    // consume the set bit so the freed slot reads as clear
                    bm_we       = 1'b1;
                    scan_next   = scan_inc;
                    k_next      = k_reg + KW'(1);
                    oldest_next = oldest_reg + 32'd1;
                    state_next  = S_ADV_RD;
                end else begin
                    base_next = scan_reg;
                    i_next    = '0;
                    w_next    = '0;
                    state_next = (k_reg == '0) ? S_DONE : S_CMP_RD;
                end
            end
            S_CMP_RD: begin
                if (i_reg >= fill_reg) begin
                    fill_next  = w_reg;
                    state_next = S_DONE;
                end else begin
                    state_next = S_CMP_CHK;
                end
            end
            S_CMP_CHK: begin
                if (fin) begin
                    emit_req         = 1'b1;
                    emit_res.kind    = KIND_DONE;
                    emit_res.status  = ST_OK;
                    emit_res.work_id = q_q_reg.id;
                    emit_res.msg     = q_q_reg.msg;
                    emit_res.seq     = q_q_reg.first_seq;
                    emit_res.amount  = q_q_reg.seg_count;
                    if (can_emit) begin
                        i_next     = i_reg + FW'(1);
                        state_next = S_CMP_RD;
                    end
                end else begin
                    // compact the survivor towards the head
                    q_we       = 1'b1;
                    q_waddr    = w_reg[QW-1:0];
                    w_next     = w_reg + FW'(1);
                    i_next     = i_reg + FW'(1);
                    state_next = S_CMP_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold one result back so the final one of an item can carry last
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_next          = m_reg;
        m_last_next     = m_last_reg;
        if (emit_req && can_emit) begin
            if (pend_valid_reg) begin
                m_valid_next = 1'b1;
                m_next       = pend_reg;
                m_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = emit_res;
        end else if (state_reg == S_DONE && out_free) begin
            m_valid_next    = 1'b1;
            m_next          = pend_reg;
            m_last_next     = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            oldest_reg     <= '0;
            nts_reg        <= '0;
            nsa_reg        <= '0;
            nmsg_reg       <= '0;
            base_reg       <= '0;
            scan_reg       <= '0;
            k_reg          <= '0;
            fill_reg       <= '0;
            i_reg          <= '0;
            w_reg          <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            oldest_reg     <= oldest_next;
            nts_reg        <= nts_next;
            nsa_reg        <= nsa_next;
            nmsg_reg       <= nmsg_next;
            base_reg       <= base_next;
            scan_reg       <= scan_next;
            k_reg          <= k_next;
            fill_reg       <= fill_next;
            i_reg          <= i_next;
            w_reg          <= w_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        off_reg    <= off_next;
        span_reg   <= span_next;
        id_reg     <= id_next;
        bytes_reg  <= bytes_next;
        ack_reg    <= ack_next;
        pend_reg   <= pend_next;
        m_reg      <= m_next;
        m_last_reg <= m_last_next;
    end

    // Bitmap memory port
    always_ff @(posedge aclk) begin
        if (bm_we) begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        bm_q_reg <= bm_mem[scan_reg];
    end

    // Queue memory port
    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[q_waddr] <= q_wdata;
        end
        q_q_reg <= q_mem[i_reg[QW-1:0]];
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_reg.kind;
    assign m_status      = m_reg.status;
    assign m_out_work_id = m_reg.work_id;
    assign m_msg_num     = m_reg.msg;
    assign m_seq_num     = m_reg.seq;
    assign m_amount      = m_reg.amount;
    assign m_last        = m_last_reg;

    `SAWT_ASSERT_IMP(a_fill_max, aclk, aresetn, 1'b1, fill_reg <= DepthF, "queue overfilled")
    `SAWT_ASSERT_NXT(a_take_one, aclk, aresetn, take_op, !s_ready, "took two items")
    `SAWT_ASSERT_IMP(a_idle_clean, aclk, aresetn, state_reg == S_IDLE, !pend_valid_reg, "result left behind")
    `SAWT_ASSERT_IMP(a_done_pend, aclk, aresetn, state_reg == S_DONE, pend_valid_reg, "item ended without result")

endmodule
